[design/target_track_rate_estimator_top_defines.svh]
// Assertion macros for the concurrent checks of the top level module.
`ifndef TARGET_TRACK_RATE_ESTIMATOR_TOP_DEFINES_SVH
`define TARGET_TRACK_RATE_ESTIMATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTRE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ttre_pkg.sv]
package ttre_pkg;

	// Field widths of the sample and result items.
	localparam int POS_W  = 31;
	localparam int YAW_W  = 16;
	localparam int VEL_W  = 32;
	localparam int THR_W  = 15;
	localparam int TICK_W = 10;

	// Position difference, its magnitude, and the scaled magnitude fed to the divider.
	localparam int DIFF_W = POS_W + 1;
	localparam int MAG_W  = POS_W;
	localparam int PROD_W = MAG_W + TICK_W;

	// Yaw wraps at a full turn of 360 degrees in 1/128 degree units.
	localparam int YAW_FULL_TURN = 46080;
	localparam int YAW_HALF_TURN = 23040;

	// Configuration port.
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = THR_W;
	localparam logic [CFG_ADDR_W-1:0] CFG_TURN_THRESHOLD = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TICK_RATE      = 1'b1;

	// Turn codes as they appear on the result.
	typedef enum logic [1:0] {
		TURN_STRAIGHT = 2'd0,
		TURN_LEFT     = 2'd1,
		TURN_RIGHT    = 2'd2
	} ttre_turn_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_OUT
	} ttre_state_t;

	// Control from the sequencer to the heading unit.
	typedef struct packed {
		logic load;    // sample transfer: write delta, read the next oldest delta
		logic update;  // apply the running sum update
		logic first;   // window was empty before this sample
		logic evict;   // window was full before this sample
	} ttre_turn_ctl_t;

endpackage

[design/target_track_rate_estimator_top.sv]
// Channel  Direction  Payload (lowest bit first)
// s_*      in         pos_x[30:0], pos_y[61:31], pos_z[92:62], yaw[108:93], zero pad to 112
// m_*      out        vel_x[31:0], vel_y[63:32], vel_z[95:64], turn_dir[97:96],
//                     turn_decided[98], zero pad to 104
// cfg_*    in         cfg_addr 0 turn_threshold, 1 tick_rate; cfg_data low bits
//
// With two or more samples in the window the result is built in order by a scaling step,
// a divider start, 41 divider steps, a check that all three dividers have finished, and
// the output load. The next input transfer is taken once the sequencer is back in idle.
// With fewer than two samples the divider start, division and finish check are skipped.
// Reset empties the window, zeroes the held velocity and turn, and restores the registers.
// A result waiting on m_tready does not block the next input transfer, only the next result.

`include "target_track_rate_estimator_top_defines.svh"

module target_track_rate_estimator_top #(
	parameter int WINDOW_LEN = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [111:0]                        s_tdata,   // pos_x, pos_y, pos_z, yaw
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [103:0]                        m_tdata,   // vel_x, vel_y, vel_z, turn_dir,
	                                                       // turn_decided
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ttre_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [ttre_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW     = $clog2(WINDOW_LEN);
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int PW     = ttre_pkg::POS_W;
	localparam int VW     = ttre_pkg::VEL_W;
	localparam int QW     = ttre_pkg::PROD_W;

	ttre_pkg::ttre_state_t    state_q;
	ttre_pkg::ttre_state_t    state_nx;
	ttre_pkg::ttre_turn_ctl_t turn_ctl;
	ttre_pkg::ttre_turn_t     turn_new;
	ttre_pkg::ttre_turn_t     turn_q;

	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     wp_inc;
	logic [AW-1:0]     rd_addr;
	logic [FILL_W-1:0] fill_q;
	logic              full_prev;
	logic              first_q;
	logic              evict_q;
	logic              accept;
	logic              div_start;
	logic              out_free;
	logic              out_load;
	logic              two_plus;
	logic              full_now;

	logic [ttre_pkg::THR_W-1:0]  thr_q;
	logic [ttre_pkg::TICK_W-1:0] tick_q;

	logic [3*PW-1:0] pos_mem [WINDOW_LEN];
	logic [3*PW-1:0] pos_rd_q;
	logic [3*PW-1:0] newest_q;

	logic [QW-1:0] mag_s2 [3];
	logic [2:0]    neg_s2;
	logic [QW-1:0] quo [3];
	logic [2:0]    div_busy;
	logic [VW-1:0] vel_q [3];
	logic          m_tvalid_q;
	logic          decided_q;

	// Saturate a signed quotient, given as magnitude and sign, to 32 bits.
	function automatic logic [VW-1:0] sat_vel(logic [QW-1:0] q, logic neg);
		logic [VW-1:0] res;
		if (!neg) begin
			res = (q > QW'({1'b0, {(VW-1){1'b1}}})) ? {1'b0, {(VW-1){1'b1}}} : q[VW-1:0];
		end else begin
			res = (q > QW'({1'b1, {(VW-1){1'b0}}})) ? {1'b1, {(VW-1){1'b0}}} :
				(~q[VW-1:0] + VW'(1));
		end
		return res;
	endfunction

	// Window pointers: the oldest entry after this sample is the slot after the write slot
	// when the window was already full, and slot zero while it fills.
	always_comb begin
		wp_inc    = (wp_q == AW'(WINDOW_LEN - 1)) ? '0 : wp_q + AW'(1);
		full_prev = fill_q == FILL_W'(WINDOW_LEN);
		rd_addr   = full_prev ? wp_inc : '0;
		two_plus  = fill_q >= FILL_W'(2);
		full_now  = fill_q == FILL_W'(WINDOW_LEN);
		out_free  = !m_tvalid_q || m_tready;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ttre_pkg::ST_IDLE:  if (s_tvalid) state_nx = ttre_pkg::ST_READ;
			ttre_pkg::ST_READ:  state_nx = two_plus ? ttre_pkg::ST_START : ttre_pkg::ST_OUT;
			ttre_pkg::ST_START: state_nx = ttre_pkg::ST_DIV;
			ttre_pkg::ST_DIV:   if (div_busy == 3'b000) state_nx = ttre_pkg::ST_OUT;
			ttre_pkg::ST_OUT:   if (out_free) state_nx = ttre_pkg::ST_IDLE;
			default:            state_nx = ttre_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready        = state_q == ttre_pkg::ST_IDLE;
		accept          = s_tvalid && s_tready;
		div_start       = state_q == ttre_pkg::ST_START;
		out_load        = (state_q == ttre_pkg::ST_OUT) && out_free;
		turn_ctl.load   = accept;
		turn_ctl.update = state_q == ttre_pkg::ST_READ;
		turn_ctl.first  = first_q;
		turn_ctl.evict  = evict_q;
	end

	// Sequencer state, window pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttre_pkg::ST_IDLE;
			wp_q    <= '0;
			fill_q  <= '0;
			first_q <= 1'b0;
			evict_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				wp_q    <= wp_inc;
				first_q <= fill_q == '0;
				evict_q <= full_prev;
				if (!full_prev) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// Config registers; the user keeps writes to idle gaps between samples, unenforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= ttre_pkg::THR_W'(128);
			tick_q <= ttre_pkg::TICK_W'(60);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				ttre_pkg::CFG_TURN_THRESHOLD: thr_q <= cfg_data;
				ttre_pkg::CFG_TICK_RATE:      tick_q <= cfg_data[ttre_pkg::TICK_W-1:0];
				default:                      thr_q <= thr_q;
			endcase
		end
	end

	// Position memory: write the new sample and read the oldest one on the same transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_mem[wp_q] <= s_tdata[3*PW-1:0];
			pos_rd_q      <= pos_mem[rd_addr];
			newest_q      <= s_tdata[3*PW-1:0];
		end
	end

	// Per axis: newest minus oldest, scaled by the tick rate, then divided by count - 1.
	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [ttre_pkg::DIFF_W-1:0] diff;
		logic [ttre_pkg::DIFF_W-1:0]        mag;

		always_comb begin
			diff = {newest_q[k*PW+PW-1], newest_q[k*PW +: PW]}
				- {pos_rd_q[k*PW+PW-1], pos_rd_q[k*PW +: PW]};
			mag  = diff[ttre_pkg::DIFF_W-1] ? -diff : diff;
		end

		always_ff @(posedge clk) begin
			if (state_q == ttre_pkg::ST_READ) begin
				mag_s2[k] <= QW'(mag[ttre_pkg::MAG_W-1:0]) * QW'(tick_q);
				neg_s2[k] <= diff[ttre_pkg::DIFF_W-1];
			end
		end

		ttre_div #(
			.NUM_W(QW),
			.DEN_W(AW)
		) u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.start (div_start),
			.num   (mag_s2[k]),
			.den   (AW'(fill_q - FILL_W'(1))),
			.busy  (div_busy[k]),
			.quo   (quo[k])
		);
	end

	// Heading unit: delta memory and running sum.
	ttre_turn #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (turn_ctl),
		.wr_addr(wp_q),
		.rd_addr(rd_addr),
		.yaw    (s_tdata[3*PW +: ttre_pkg::YAW_W]),
		.thr    (thr_q),
		.turn   (turn_new)
	);

	// Output register; it also holds the last velocity and turn between updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			decided_q  <= 1'b0;
			turn_q     <= ttre_pkg::TURN_STRAIGHT;
			vel_q[0]   <= '0;
			vel_q[1]   <= '0;
			vel_q[2]   <= '0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
			decided_q  <= full_now;
			if (full_now) begin
				turn_q <= turn_new;
			end
			if (two_plus) begin
				vel_q[0] <= sat_vel(quo[0], neg_s2[0]);
				vel_q[1] <= sat_vel(quo[1], neg_s2[1]);
				vel_q[2] <= sat_vel(quo[2], neg_s2[2]);
			end
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, decided_q, turn_q, vel_q[2], vel_q[1], vel_q[0]};

	// A transfer always leads straight into the memory read cycle.
	`TTRE_ASSERT_NEXT(a_accept_read, clk, arst_n, accept, state_q == ttre_pkg::ST_READ,
		"sample transfer not followed by the read cycle")
	// The fill count never passes the window length.
	`TTRE_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(WINDOW_LEN),
		"fill count beyond window length")
	// A decided turn is only shown with a full window.
	`TTRE_ASSERT_SAME(a_decided_full, clk, arst_n, m_tvalid_q && decided_q, full_now,
		"turn decided with a window that is not full")
	// The dividers have finished before the result is loaded.
	`TTRE_ASSERT_SAME(a_div_idle_out, clk, arst_n, state_q == ttre_pkg::ST_OUT,
		div_busy == 3'b000, "result stage reached while a divider runs")

endmodule

[design/ttre_div.sv]
module ttre_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// One restoring step: shift in the next numerator bit and try the divisor.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register; the numerator enters in the quotient slot.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

[design/ttre_turn.sv]
module ttre_turn #(
	parameter int WINDOW_LEN = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ttre_pkg::ttre_turn_ctl_t             ctl,
	input  logic [$clog2(WINDOW_LEN)-1:0]        wr_addr,
	input  logic [$clog2(WINDOW_LEN)-1:0]        rd_addr,
	input  logic signed [ttre_pkg::YAW_W-1:0]    yaw,
	input  logic [ttre_pkg::THR_W-1:0]           thr,
	output ttre_pkg::ttre_turn_t                 turn
);

	localparam int YW     = ttre_pkg::YAW_W;
	localparam int LW     = $clog2(WINDOW_LEN);
	localparam int DSUM_W = YW + LW;
	localparam int CMP_W  = DSUM_W + 1;
	localparam logic signed [YW:0] HALF = (YW + 1)'(ttre_pkg::YAW_HALF_TURN);
	localparam logic signed [YW:0] FULL = (YW + 1)'(ttre_pkg::YAW_FULL_TURN);

	logic signed [YW-1:0]     delta_mem [WINDOW_LEN];
	logic signed [YW-1:0]     last_yaw_q;
	logic signed [YW-1:0]     drop_q;
	logic signed [YW-1:0]     add_q;
	logic signed [DSUM_W-1:0] sum_q;
	logic signed [YW:0]       yaw_diff;
	logic signed [YW:0]       yaw_wrap;
	logic signed [DSUM_W-1:0] add_ext;
	logic signed [DSUM_W-1:0] drop_ext;
	logic signed [CMP_W-1:0]  sum_ext;
	logic signed [CMP_W-1:0]  limit;

	// Heading change since the previous sample, brought into (-half turn, half turn].
	always_comb begin
		yaw_diff = {yaw[YW-1], yaw} - {last_yaw_q[YW-1], last_yaw_q};
		if (yaw_diff > HALF) begin
			yaw_wrap = yaw_diff - FULL;
		end else if (yaw_diff <= -HALF) begin
			yaw_wrap = yaw_diff + FULL;
		end else begin
			yaw_wrap = yaw_diff;
		end
	end

	// Delta memory: each entry holds the wrapped change that brought in its sample.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			delta_mem[wr_addr] <= yaw_wrap[YW-1:0];
			drop_q             <= delta_mem[rd_addr];
			add_q              <= yaw_wrap[YW-1:0];
			last_yaw_q         <= yaw;
		end
	end

	assign add_ext  = {{(DSUM_W - YW){add_q[YW-1]}}, add_q};
	assign drop_ext = {{(DSUM_W - YW){drop_q[YW-1]}}, drop_q};

	// Running sum over the deltas of every sample in the window except the oldest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.update) begin
			priority if (ctl.evict) begin
				sum_q <= sum_q - drop_ext + add_ext;
			end else if (!ctl.first) begin
				sum_q <= sum_q + add_ext;
			end else begin
				sum_q <= sum_q;
			end
		end
	end

	// Compare the sum against the threshold scaled by the number of deltas.
	always_comb begin
		sum_ext = {sum_q[DSUM_W-1], sum_q};
		limit   = $signed(CMP_W'(thr) * CMP_W'(WINDOW_LEN - 1));
		priority if (sum_ext > limit) begin
			turn = ttre_pkg::TURN_LEFT;
		end else if (sum_ext < -limit) begin
			turn = ttre_pkg::TURN_RIGHT;
		end else begin
			turn = ttre_pkg::TURN_STRAIGHT;
		end
	end

endmodule

[tb/target_track_rate_estimator_top_tb.sv]
module target_track_rate_estimator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LEN      = 8;
	localparam int SETTLE_CYCLES   = 64;
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int REPORT_LIMIT    = 10;

	localparam longint VEL_MAX = 64'sd2147483647;
	localparam longint VEL_MIN = -64'sd2147483648;
	localparam logic signed [ttre_pkg::POS_W-1:0] POS_MAX =
		{1'b0, {(ttre_pkg::POS_W-1){1'b1}}};
	localparam logic signed [ttre_pkg::POS_W-1:0] POS_MIN =
		{1'b1, {(ttre_pkg::POS_W-1){1'b0}}};

	typedef struct {
		logic signed [ttre_pkg::POS_W-1:0] pos_x;
		logic signed [ttre_pkg::POS_W-1:0] pos_y;
		logic signed [ttre_pkg::POS_W-1:0] pos_z;
		logic signed [ttre_pkg::YAW_W-1:0] yaw;
	} sample_t;

	typedef struct {
		logic signed [ttre_pkg::VEL_W-1:0] vel_x;
		logic signed [ttre_pkg::VEL_W-1:0] vel_y;
		logic signed [ttre_pkg::VEL_W-1:0] vel_z;
		ttre_pkg::ttre_turn_t              turn_dir;
		logic                              turn_decided;
	} estimate_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [111:0]                    s_tdata   = '0;  // pos_x, pos_y, pos_z, yaw
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [103:0]                    m_tdata;         // vel_x, vel_y, vel_z, turn_dir,
	                                                  // turn_decided
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ttre_pkg::CFG_ADDR_W-1:0] cfg_addr  = ttre_pkg::CFG_TURN_THRESHOLD;
	logic [ttre_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor state, mirroring the block after reset.
	logic signed [ttre_pkg::POS_W-1:0] hist_x   [WINDOW_LEN];
	logic signed [ttre_pkg::POS_W-1:0] hist_y   [WINDOW_LEN];
	logic signed [ttre_pkg::POS_W-1:0] hist_z   [WINDOW_LEN];
	logic signed [ttre_pkg::YAW_W-1:0] hist_yaw [WINDOW_LEN];
	int unsigned                       fill_count_q = 0;
	int unsigned                       wr_slot_q    = 0;
	logic signed [ttre_pkg::VEL_W-1:0] held_vx      = '0;
	logic signed [ttre_pkg::VEL_W-1:0] held_vy      = '0;
	logic signed [ttre_pkg::VEL_W-1:0] held_vz      = '0;
	ttre_pkg::ttre_turn_t              held_turn_q  = ttre_pkg::TURN_STRAIGHT;
	int unsigned                       threshold_q  = 128;
	int unsigned                       tick_rate_q  = 60;

	estimate_t   pending_estimates [$];
	int unsigned mismatch_count = 0;
	int unsigned result_count   = 0;
	int unsigned cycle_count    = 0;
	bit          burst_mode     = 1'b0;

	target_track_rate_estimator_top #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Give up on a hung block.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Reduce a yaw difference into the half-open range (-half turn, +half turn].
	function automatic longint wrapped_heading_delta(input longint now_yaw,
			input longint prev_yaw);
		longint d;
		d = (now_yaw - prev_yaw) % ttre_pkg::YAW_FULL_TURN;
		if (d < 0)
			d += ttre_pkg::YAW_FULL_TURN;
		if (d > ttre_pkg::YAW_HALF_TURN)
			d -= ttre_pkg::YAW_FULL_TURN;
		return d;
	endfunction

	// Position change over the window, scaled to per second, truncated and saturated.
	function automatic logic signed [ttre_pkg::VEL_W-1:0] rate_of_change(input longint newest,
			input longint oldest, input int unsigned count);
		longint q;
		q = ((newest - oldest) * longint'(tick_rate_q)) / longint'(count - 1);
		if (q > VEL_MAX)
			q = VEL_MAX;
		if (q < VEL_MIN)
			q = VEL_MIN;
		return q[ttre_pkg::VEL_W-1:0];
	endfunction

	// Push one sample into the window and work out the velocity and turn it yields.
	function automatic estimate_t estimate_rates(input sample_t smp);
		estimate_t   est;
		int unsigned slot;
		int unsigned oldest;
		int unsigned a;
		int unsigned b;
		int unsigned i;
		longint      heading_sum;
		longint      limit;
		slot = wr_slot_q;
		hist_x[slot] = smp.pos_x;
		hist_y[slot] = smp.pos_y;
		hist_z[slot] = smp.pos_z;
		hist_yaw[slot] = smp.yaw;
		if (fill_count_q < WINDOW_LEN)
			fill_count_q++;
		oldest = (slot + WINDOW_LEN - (fill_count_q - 1)) % WINDOW_LEN;
		wr_slot_q = (slot + 1) % WINDOW_LEN;
		if (fill_count_q >= 2) begin
			held_vx = rate_of_change(hist_x[slot], hist_x[oldest], fill_count_q);
			held_vy = rate_of_change(hist_y[slot], hist_y[oldest], fill_count_q);
			held_vz = rate_of_change(hist_z[slot], hist_z[oldest], fill_count_q);
		end
		est.turn_decided = 1'b0;
		if (fill_count_q >= WINDOW_LEN) begin
			heading_sum = 0;
			for (i = 1; i < WINDOW_LEN; i++) begin
				a = (oldest + i - 1) % WINDOW_LEN;
				b = (oldest + i) % WINDOW_LEN;
				heading_sum += wrapped_heading_delta(hist_yaw[b], hist_yaw[a]);
			end
			limit = longint'(threshold_q) * (WINDOW_LEN - 1);
			if (heading_sum > limit)
				held_turn_q = ttre_pkg::TURN_LEFT;
			else if (heading_sum < -limit)
				held_turn_q = ttre_pkg::TURN_RIGHT;
			else
				held_turn_q = ttre_pkg::TURN_STRAIGHT;
			est.turn_decided = 1'b1;
		end
		est.vel_x = held_vx;
		est.vel_y = held_vy;
		est.vel_z = held_vz;
		est.turn_dir = held_turn_q;
		return est;
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] result %0d: %s", $time, result_count, what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
	endtask

	// Check every result transfer against the oldest pending estimate.
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (pending_estimates.size() == 0) begin
				note_mismatch($sformatf("result with nothing pending, data %h", m_tdata));
			end else begin
				want = pending_estimates[0];
				pending_estimates.delete(0);
				compare_field("vel_x", want.vel_x, m_tdata[31:0]);
				compare_field("vel_y", want.vel_y, m_tdata[63:32]);
				compare_field("vel_z", want.vel_z, m_tdata[95:64]);
				compare_field("turn_dir", 32'(want.turn_dir), 32'(m_tdata[97:96]));
				compare_field("turn_decided", 32'(want.turn_decided), 32'(m_tdata[98]));
			end
		end
	end

	// Result side pacing: ready runs, short and occasional long stalls.
	initial begin : sink_pacing
		int unsigned ready_len;
		int unsigned stall_len;
		int unsigned roll;
		@(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			ready_len = (roll < 10) ? $urandom_range(100, 300) : $urandom_range(1, 24);
			roll = $urandom_range(0, 99);
			if (roll < 50)
				stall_len = 0;
			else if (roll < 85)
				stall_len = $urandom_range(1, 4);
			else if (roll < 97)
				stall_len = $urandom_range(5, 15);
			else
				stall_len = $urandom_range(30, 80);
			m_tready <= 1'b1;
			repeat (ready_len) @(posedge clk);
			if (stall_len != 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (burst_mode || roll < 45)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic sample_t make_sample(input longint x, input longint y, input longint z,
			input longint heading);
		sample_t smp;
		smp.pos_x = ttre_pkg::POS_W'(x);
		smp.pos_y = ttre_pkg::POS_W'(y);
		smp.pos_z = ttre_pkg::POS_W'(z);
		smp.yaw = ttre_pkg::YAW_W'(heading);
		return smp;
	endfunction

	function automatic int wrap_heading(input int heading);
		if (heading > ttre_pkg::YAW_HALF_TURN)
			heading -= ttre_pkg::YAW_FULL_TURN;
		else if (heading < -ttre_pkg::YAW_HALF_TURN)
			heading += ttre_pkg::YAW_FULL_TURN;
		return heading;
	endfunction

	// Offer one sample; valid stays high after the transfer so back-to-back samples
	// go out without valid dropping in between.
	task automatic send_sample(input sample_t smp);
		int unsigned gap;
		estimate_t   est;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, smp.yaw, smp.pos_z, smp.pos_y, smp.pos_x};
		do @(posedge clk); while (!s_tready);
		est = estimate_rates(smp);
		pending_estimates = {pending_estimates, est};
	endtask

	// Stop sending and let every pending result come back.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high after the transfer; the caller lowers it.
	task automatic write_register(input logic [ttre_pkg::CFG_ADDR_W-1:0] addr,
			input logic [ttre_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (addr == ttre_pkg::CFG_TURN_THRESHOLD)
			threshold_q = value;
		else
			tick_rate_q = value[ttre_pkg::TICK_W-1:0];
	endtask

	task automatic apply_settings(input int unsigned threshold, input int unsigned rate_word);
		wait_for_drain();
		write_register(ttre_pkg::CFG_TURN_THRESHOLD, ttre_pkg::CFG_DATA_W'(threshold));
		write_register(ttre_pkg::CFG_TICK_RATE, ttre_pkg::CFG_DATA_W'(rate_word));
		cfg_valid <= 1'b0;
	endtask

	function automatic longint random_step();
		longint mag;
		mag = longint'($urandom_range(0, 1 << $urandom_range(0, 24)));
		return ($urandom_range(0, 1) != 0) ? -mag : mag;
	endfunction

	function automatic logic signed [ttre_pkg::POS_W-1:0] corner_position();
		case ($urandom_range(0, 4))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return '0;
			3: return '1;
			default: return ttre_pkg::POS_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [ttre_pkg::YAW_W-1:0] corner_heading();
		case ($urandom_range(0, 4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return ttre_pkg::YAW_W'(ttre_pkg::YAW_HALF_TURN);
			3: return ttre_pkg::YAW_W'(-ttre_pkg::YAW_HALF_TURN);
			default: return '0;
		endcase
	endfunction

	function automatic int unsigned pick_threshold();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return ttre_pkg::YAW_HALF_TURN;
			2: return (1 << ttre_pkg::THR_W) - 1;
			3, 4: return $urandom_range(0, 600);
			default: return $urandom_range(0, (1 << ttre_pkg::THR_W) - 1);
		endcase
	endfunction

	function automatic int unsigned pick_rate_word();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 1000;
			3: return (1 << ttre_pkg::TICK_W) - 1;
			4: return $urandom_range(0, (1 << ttre_pkg::CFG_DATA_W) - 1);
			default: return $urandom_range(1, 1000);
		endcase
	endfunction

	// Single sample, saturating velocities, odd yaws, then a steady left and right turn.
	task automatic test_window_fill();
		int yaw_track;
		int k;
		send_sample(make_sample(POS_MAX, POS_MIN, 0, ttre_pkg::YAW_HALF_TURN));
		send_sample(make_sample(POS_MIN, POS_MAX, 1, -ttre_pkg::YAW_HALF_TURN));
		send_sample(make_sample(POS_MIN, POS_MAX, -1, 32767));
		send_sample(make_sample(0, -1, POS_MIN, -32768));
		yaw_track = 20000;
		for (k = 0; k < 8; k++) begin
			send_sample(make_sample(1000 * k, -37 * k, 5, yaw_track));
			yaw_track = wrap_heading(yaw_track + 1000);
		end
		for (k = 8; k < 12; k++) begin
			yaw_track = wrap_heading(yaw_track - 1000);
			send_sample(make_sample(1000 * k, -37 * k, 5, yaw_track));
		end
	endtask

	// Zero and full-width register values, with an over-range tick rate word.
	task automatic test_register_extremes();
		int k;
		apply_settings(0, 0);
		for (k = 0; k < 3; k++)
			send_sample(make_sample(-500 * k, 77, POS_MAX, 0));
		apply_settings((1 << ttre_pkg::THR_W) - 1, (1 << ttre_pkg::CFG_DATA_W) - 1);
		send_sample(make_sample(POS_MAX, POS_MAX, POS_MIN, 16'sh8000));
		send_sample(make_sample(POS_MIN, POS_MIN, POS_MAX, 16'sh7FFF));
		send_sample(make_sample(POS_MAX, 0, -1, 0));
		apply_settings(ttre_pkg::YAW_HALF_TURN, 1000);
		for (k = 0; k < 3; k++)
			send_sample(make_sample(POS_MIN + k, 3 * k, -k, ttre_pkg::YAW_HALF_TURN));
	endtask

	// Mostly smooth tracks with random turn rates near the threshold; some noise and corners.
	task automatic test_random_tracks();
		sample_t     cur;
		longint      step_x;
		longint      step_y;
		longint      step_z;
		int          yaw_now;
		int          yaw_rate;
		int          span;
		int unsigned phase;
		int unsigned sent;
		int unsigned seg_len;
		int unsigned kind;
		cur = make_sample(0, 0, 0, 0);
		yaw_now = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			apply_settings(pick_threshold(), pick_rate_word());
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				seg_len = $urandom_range(4, 40);
				if (seg_len > ITEMS_PER_PHASE - sent)
					seg_len = ITEMS_PER_PHASE - sent;
				kind = $urandom_range(0, 9);
				burst_mode = ($urandom_range(0, 3) == 0);
				step_x = random_step();
				step_y = random_step();
				step_z = random_step();
				span = (threshold_q > 11000) ? ttre_pkg::YAW_HALF_TURN :
					2 * int'(threshold_q) + 64;
				yaw_rate = $urandom_range(0, 2 * span) - span;
				repeat (seg_len) begin
					if (kind < 7) begin
						cur.pos_x = ttre_pkg::POS_W'(cur.pos_x + step_x);
						cur.pos_y = ttre_pkg::POS_W'(cur.pos_y + step_y);
						cur.pos_z = ttre_pkg::POS_W'(cur.pos_z + step_z);
						yaw_now = wrap_heading(yaw_now + yaw_rate + $urandom_range(0, 8) - 4);
						cur.yaw = ttre_pkg::YAW_W'(yaw_now);
					end else if (kind < 9) begin
						cur.pos_x = ttre_pkg::POS_W'($urandom());
						cur.pos_y = ttre_pkg::POS_W'($urandom());
						cur.pos_z = ttre_pkg::POS_W'($urandom());
						cur.yaw = ttre_pkg::YAW_W'($urandom());
					end else begin
						cur.pos_x = corner_position();
						cur.pos_y = corner_position();
						cur.pos_z = corner_position();
						cur.yaw = corner_heading();
					end
					send_sample(cur);
					sent++;
				end
			end
		end
		burst_mode = 1'b0;
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_fill();
		test_register_extremes();
		test_random_tracks();
		wait_for_drain();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
